// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after an antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfae_pkg.sv =====
package rfae_pkg;

  localparam int MODE_W = 4;
  localparam int IDX_W  = 4;
  localparam int IMM_W  = 64;
  localparam int FLAG_W = 3;

  typedef enum logic [MODE_W-1:0] {
    OP_COPY = 4'd0,
    OP_OR   = 4'd1,
    OP_AND  = 4'd2,
    OP_XOR  = 4'd3,
    OP_NOT  = 4'd4,
    OP_ADD  = 4'd5,
    OP_SUB  = 4'd6,
    OP_MUL  = 4'd7,
    OP_DIV  = 4'd8,
    OP_SHL  = 4'd9,
    OP_SHR  = 4'd10,
    OP_CMP  = 4'd11
  } op_t;

  localparam logic [FLAG_W-1:0] FLAG_GREATER = 3'b001;
  localparam logic [FLAG_W-1:0] FLAG_LESS    = 3'b010;
  localparam logic [FLAG_W-1:0] FLAG_EQUAL   = 3'b100;

  localparam logic [5:0] SHIFT_MASK = 6'h3F;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              use_immediate;
    logic [IDX_W-1:0]  dest_reg;
    logic [IDX_W-1:0]  src_reg;
    logic [IMM_W-1:0]  immediate;
  } instr_t;

  typedef struct packed {
    logic              write_enable;
    logic [IMM_W-1:0]  written_value;
    logic [FLAG_W-1:0] compare_flags;
    logic              error_code;
  } result_t;

endpackage

// ===== rtl/rfae_stream_if.sv =====
interface rfae_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/rfae_regmem.sv =====
module rfae_regmem #(
  parameter int REGISTER_COUNT = 16,
  parameter int DATA_WIDTH     = 64,
  parameter int AW             = 4
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr_a,
  input  logic [AW-1:0]         rd_addr_b,
  output logic [DATA_WIDTH-1:0] rd_data_a,
  output logic [DATA_WIDTH-1:0] rd_data_b,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [DATA_WIDTH-1:0] wr_data
);

  logic [DATA_WIDTH-1:0] mem [REGISTER_COUNT];

  // Write one entry, read two registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ===== rtl/rfae_divider.sv =====
module rfae_divider #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] dividend,
  input  logic [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] dsr;
  logic [CW-1:0]         count;
  logic                  busy;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;

  // Shift in one dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[DATA_WIDTH-1]};
    diff  = trial - {1'b0, dsr};
  end

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= !start && busy && (count == CW'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(DATA_WIDTH);
        rem   <= '0;
        quo   <= dividend;
        dsr   <= divisor;
      end else if (busy) begin
        if (diff[DATA_WIDTH]) begin
          rem <= trial[DATA_WIDTH-1:0];
          quo <= {quo[DATA_WIDTH-2:0], 1'b0};
        end else begin
          rem <= diff[DATA_WIDTH-1:0];
          quo <= {quo[DATA_WIDTH-2:0], 1'b1};
        end
        count <= count - CW'(1);
        busy  <= (count != CW'(1));
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== rtl/register_file_alu_execute.sv =====
// Channel | Dir | Payload
// req     | in  | mode, use_immediate, dest_reg, src_reg, immediate
// rsp     | out | write_enable, written_value, compare_flags, error_code
//
// One request at a time. Ops that finish in the execute step go through register read,
// execute and write back; multiply adds the ST_MUL state for the partial products; a
// nonzero divide waits in ST_DIV for the bit-serial divider before write back.
// After reset a clearing pass writes zero to each register, with no request accepted.
// A stalled result holds in the output register; the next request is accepted and
// waits at write back until it leaves.
module register_file_alu_execute #(
  parameter int REGISTER_COUNT = 16,
  parameter int DATA_WIDTH     = 64
) (
  input  logic        clk,
  input  logic        rst,
  rfae_stream_if.sink   req,
  rfae_stream_if.source rsp
);
  import rfae_pkg::*;

  localparam int AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int PW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int HW = DATA_WIDTH - PW;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_EXEC  = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state;
  instr_t ins;
  logic [AW-1:0] d_idx, s_idx, clr_idx;
  logic [DATA_WIDTH-1:0] rd_a, rd_b, a, b, res;
  logic [FLAG_W-1:0] flags;
  logic wr, err;
  logic [2*PW-1:0] p_ll, p_lh, p_hl;
  logic div_start, div_done;
  logic [DATA_WIDTH-1:0] quo;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic [DATA_WIDTH-1:0] mem_wd;
  logic rsp_valid;
  result_t rsp_q;
  logic [DATA_WIDTH-1:0] res_next;
  logic wr_next, err_next;
  logic [FLAG_W-1:0] flags_next;
  state_t exec_next;

  // Wrap indices modulo the register count through a constant table
  function automatic logic [AW-1:0] wrap_idx(logic [IDX_W-1:0] i);
    logic [AW-1:0] r;
    r = '0;
    for (int k = 0; k < 2**IDX_W; k++) begin
      if (i == IDX_W'(k)) r = AW'(k % REGISTER_COUNT);
    end
    return r;
  endfunction

  assign d_idx = wrap_idx(ins.dest_reg);
  assign s_idx = wrap_idx(ins.src_reg);

  rfae_regmem #(.REGISTER_COUNT(REGISTER_COUNT), .DATA_WIDTH(DATA_WIDTH), .AW(AW)) u_mem (
    .clk, .rd_en(state == ST_READ), .rd_addr_a(d_idx), .rd_addr_b(s_idx),
    .rd_data_a(rd_a), .rd_data_b(rd_b),
    .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd)
  );

  assign a = rd_a;
  assign b = ins.use_immediate ? ins.immediate[DATA_WIDTH-1:0] : rd_b;

  rfae_divider #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk, .rst, .start(div_start), .dividend(a), .divisor(b),
    .done(div_done), .quotient(quo)
  );

  assign div_start = (state == ST_EXEC) && (op_t'(ins.mode) == OP_DIV) && (b != '0);

  // Split multiply into registered partial products
  always_ff @(posedge clk) begin
    p_ll <= (2*PW)'(a[PW-1:0]) * (2*PW)'(b[PW-1:0]);
    if (HW > 0) begin
      p_lh <= (2*PW)'(a[PW-1:0]) * (2*PW)'(b[DATA_WIDTH-1 -: PW] >> (PW - HW));
      p_hl <= (2*PW)'(a[DATA_WIDTH-1 -: PW] >> (PW - HW)) * (2*PW)'(b[PW-1:0]);
    end else begin
      p_lh <= '0;
      p_hl <= '0;
    end
  end

  // Execute the held request against the operands read
  always_comb begin
    res_next   = a;
    wr_next    = 1'b1;
    err_next   = 1'b0;
    flags_next = flags;
    exec_next  = ST_DONE;
    unique case (ins.mode)
      OP_COPY: res_next = b;
      OP_OR:   res_next = a | b;
      OP_AND:  res_next = a & b;
      OP_XOR:  res_next = a ^ b;
      OP_NOT:  res_next = ~b;
      OP_ADD:  res_next = a + b;
      OP_SUB:  res_next = a - b;
      OP_MUL:  exec_next = ST_MUL;
      OP_DIV: begin
        if (b == '0) begin
          wr_next  = 1'b0;
          err_next = 1'b1;
        end else begin
          exec_next = ST_DIV;
        end
      end
      OP_SHL:  res_next = DATA_WIDTH'({64'b0, a} << (b[5:0] & SHIFT_MASK));
      OP_SHR:  res_next = DATA_WIDTH'({64'b0, a} >> (b[5:0] & SHIFT_MASK));
      OP_CMP: begin
        wr_next = 1'b0;
        flags_next = flags | ((a > b) ? FLAG_GREATER : '0)
                           | ((a < b) ? FLAG_LESS : '0)
                           | ((a == b) ? FLAG_EQUAL : '0);
      end
      default: wr_next = 1'b0;
    endcase
  end

  assign mem_we = (state == ST_CLEAR) || ((state == ST_DONE) && wr && !rsp_valid);
  assign mem_wa = (state == ST_CLEAR) ? clr_idx : d_idx;
  assign mem_wd = (state == ST_CLEAR) ? '0 : res;

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.payload = rsp_q;

  // Sequence each request through read, execute and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      flags     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(REGISTER_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            ins   <= req.payload;
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_EXEC;
        ST_EXEC: begin
          wr    <= wr_next;
          err   <= err_next;
          res   <= res_next;
          flags <= flags_next;
          state <= exec_next;
        end
        ST_MUL: begin
          res <= DATA_WIDTH'(p_ll + ((2*PW)'(p_lh + p_hl) << PW));
          state <= ST_DONE;
        end
        ST_DIV: begin
          if (div_done) begin
            res   <= quo;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp_valid) begin
            rsp_valid <= 1'b1;
            rsp_q.write_enable  <= wr;
            rsp_q.written_value <= IMM_W'(res);
            rsp_q.compare_flags <= flags;
            rsp_q.error_code    <= err;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rfae_checker.sv =====
module rfae_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_we,
  input logic rsp_err,
  input logic [2:0] rsp_flags
);
  `include "assert_macros.svh"

  `ASSERT_IMPL(a_err_no_write, rsp_valid && rsp_err, !rsp_we, "error result wrote a register")
  `ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
  `ASSERT_NEXT(a_flags_sticky, rsp_valid && rsp_ready, !rsp_valid || ((rsp_flags & $past(rsp_flags)) == $past(rsp_flags)), "flags cleared")
  `ASSERT_NEXT(a_one_at_time, req_valid && req_ready, !req_ready, "second request taken before result")
endmodule

bind register_file_alu_execute rfae_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_we(rsp.payload.write_enable), .rsp_err(rsp.payload.error_code),
  .rsp_flags(rsp.payload.compare_flags)
);

// ===== tb/tb_register_file_alu_execute.sv =====
`timescale 1ns / 100ps

class exec_scoreboard;
  logic [63:0] regs [16];
  logic [2:0] flags;
  rfae_pkg::result_t pending_results [$];
  int mismatches;
  int result_count;

  function void clear();
    foreach (regs[i]) regs[i] = '0;
    flags = '0;
    pending_results.delete();
    mismatches = 0;
    result_count = 0;
  endfunction

  // predict the result of one accepted request and update the register copy
  function void note_request(rfae_pkg::instr_t ins);
    rfae_pkg::result_t r;
    logic [63:0] a, b, res;
    logic wr;
    logic err;
    a = regs[ins.dest_reg];
    b = ins.use_immediate ? ins.immediate : regs[ins.src_reg];
    res = a;
    wr = 1'b1;
    err = 1'b0;
    case (ins.mode)
      rfae_pkg::OP_COPY: res = b;
      rfae_pkg::OP_OR:   res = a | b;
      rfae_pkg::OP_AND:  res = a & b;
      rfae_pkg::OP_XOR:  res = a ^ b;
      rfae_pkg::OP_NOT:  res = ~b;
      rfae_pkg::OP_ADD:  res = a + b;
      rfae_pkg::OP_SUB:  res = a - b;
      rfae_pkg::OP_MUL:  res = a * b;
      rfae_pkg::OP_DIV: begin
        if (b == 0) begin
          wr = 1'b0;
          err = 1'b1;
        end else begin
          res = a / b;
        end
      end
      rfae_pkg::OP_SHL:  res = a << b[5:0];
      rfae_pkg::OP_SHR:  res = a >> b[5:0];
      rfae_pkg::OP_CMP: begin
        wr = 1'b0;
        if (a > b) flags = flags | rfae_pkg::FLAG_GREATER;
        if (a < b) flags = flags | rfae_pkg::FLAG_LESS;
        if (a == b) flags = flags | rfae_pkg::FLAG_EQUAL;
      end
      default: wr = 1'b0;
    endcase
    if (wr) regs[ins.dest_reg] = res;
    else res = a;
    r.write_enable = wr;
    r.written_value = res;
    r.compare_flags = flags;
    r.error_code = err;
    pending_results.push_back(r);
  endfunction

  // compare one accepted result with the oldest prediction
  function void check_result(rfae_pkg::result_t got);
    rfae_pkg::result_t want;
    result_count++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending_results.pop_front();
    if (got.write_enable !== want.write_enable || got.written_value !== want.written_value ||
        got.compare_flags !== want.compare_flags || got.error_code !== want.error_code) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d mismatch: expected %p, actual %p", result_count, want, got);
    end
  endfunction
endclass

module tb_register_file_alu_execute;
  import rfae_pkg::*;

  localparam int RANDOM_REQUESTS = 1630;
  localparam int QUIET_TAIL = 200;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  rfae_stream_if #(.payload_t(instr_t)) req ();
  rfae_stream_if #(.payload_t(result_t)) rsp ();

  exec_scoreboard board;
  bit quiet;
  longint cycles;

  register_file_alu_execute uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always #4 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b0;
    board = new();
    board.clear();
  end

  // stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // check each result as it is taken
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) board.check_result(rsp.payload);
  end

  // drive ready with random stall bursts
  initial begin
    int n;
    cycles = 0;
    @(posedge clk);
    forever begin
      if (quiet || $urandom_range(0, 2) != 0) begin
        rsp.ready <= 1'b1;
        n = $urandom_range(1, 30);
      end else begin
        rsp.ready <= 1'b0;
        n = $urandom_range(1, 17);
      end
      repeat (n) @(posedge clk);
    end
  end

  function automatic logic [63:0] rand_word();
    logic [63:0] w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = 64'd1;
      3: w = {1'b1, 63'd0};
      4: w = 64'($urandom_range(0, 70));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // present one request and hold it until accepted
  task automatic send_request(instr_t ins);
    req.valid <= 1'b1;
    req.payload <= ins;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    board.note_request(ins);
  endtask

  task automatic idle_sender();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  function automatic instr_t make_request(logic [3:0] m, logic ui, logic [3:0] d,
                                          logic [3:0] s, logic [63:0] imm);
    instr_t ins;
    ins.mode = m;
    ins.use_immediate = ui;
    ins.dest_reg = d;
    ins.src_reg = s;
    ins.immediate = imm;
    return ins;
  endfunction

  initial begin
    int i;
    instr_t ins;
    logic [3:0] m;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every operation, divide by zero, compares, unused modes
    send_request(make_request(OP_COPY, 1'b1, 4'd0, 4'd0, '1));
    send_request(make_request(OP_COPY, 1'b1, 4'd15, 4'd0, 64'd7));
    send_request(make_request(OP_COPY, 1'b0, 4'd1, 4'd15, '0));
    send_request(make_request(OP_OR, 1'b1, 4'd2, 4'd0, 64'hF0F0));
    send_request(make_request(OP_AND, 1'b0, 4'd2, 4'd0, '0));
    send_request(make_request(OP_XOR, 1'b1, 4'd3, 4'd0, {1'b1, 63'd5}));
    send_request(make_request(OP_NOT, 1'b0, 4'd4, 4'd3, '0));
    send_request(make_request(OP_ADD, 1'b0, 4'd0, 4'd15, '0));
    send_request(make_request(OP_SUB, 1'b1, 4'd5, 4'd0, 64'd1));
    send_request(make_request(OP_MUL, 1'b0, 4'd5, 4'd5, '0));
    send_request(make_request(OP_DIV, 1'b1, 4'd15, 4'd0, '0));
    send_request(make_request(OP_DIV, 1'b0, 4'd0, 4'd15, '0));
    send_request(make_request(OP_DIV, 1'b1, 4'd0, 4'd0, 64'd1));
    send_request(make_request(OP_SHL, 1'b1, 4'd15, 4'd0, 64'hFFC3));
    send_request(make_request(OP_SHR, 1'b1, 4'd0, 4'd0, 64'd63));
    send_request(make_request(OP_SHR, 1'b0, 4'd3, 4'd15, '0));
    send_request(make_request(OP_CMP, 1'b1, 4'd1, 4'd0, 64'd5));
    send_request(make_request(OP_CMP, 1'b1, 4'd15, 4'd0, 64'd0));
    send_request(make_request(OP_CMP, 1'b0, 4'd6, 4'd7, '0));
    for (i = 12; i < 16; i++) send_request(make_request(4'(i), 1'b0, 4'd1, 4'd2, '1));

    // wait for the block to drain before resuming
    req.valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);

    // random requests, last stretch without idling
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i == RANDOM_REQUESTS - QUIET_TAIL) quiet = 1'b1;
      m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                       : 4'($urandom_range(0, 11));
      ins = make_request(m, 1'($urandom), 4'($urandom), 4'($urandom), rand_word());
      if (m == OP_DIV && ins.use_immediate && $urandom_range(0, 3) == 0)
        ins.immediate = 64'($urandom_range(0, 3));
      if ((m == OP_SHL || m == OP_SHR) && $urandom_range(0, 1) == 0)
        ins.immediate[5:0] = $urandom_range(0, 1) ? 6'h3F : 6'h00;
      send_request(ins);
      idle_sender();
    end
    req.valid <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
